// ----- hw/rtl/lcs_pkg.sv -----
// Shared types, constants and fixed-point helpers of the Langevin chain step unit.
`default_nettype none

package lcs_pkg;

	// Sizing of the chain and of the fixed-point format
	localparam int MAX_PARTICLES = 64;
	localparam int FRAC_BITS     = 16;
	localparam int IDX_W         = $clog2(MAX_PARTICLES);
	localparam int NW            = IDX_W + 1;
	localparam int PCOUNT_W      = 7;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 31;

	// Reciprocal unit: two quotient bits per stage
	localparam int DIV_BITS   = 2 * FRAC_BITS;
	localparam int DIV_STAGES = DIV_BITS / 2;

	// Latencies: force pipe (input, divider, select, five multiplies, sum) and update pipe
	localparam int FORCE_LAT = DIV_STAGES + 8;
	localparam int UPD_LAT   = 4;
	localparam int RING_LEN  = MAX_PARTICLES + FORCE_LAT + 1 + UPD_LAT;
	localparam int CNT_W     = $clog2(RING_LEN);

	// Request modes
	localparam logic [1:0] MODE_STEP  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 3'd6;

	localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
	localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [1:0]        mode;
		logic [5:0]        particle_index;
		logic signed [31:0] write_position;
		logic signed [31:0] write_velocity;
		logic signed [31:0] left_noise;
		logic signed [31:0] right_noise;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_position;
		logic signed [31:0] read_velocity;
	} res_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] v;
	} particle_t;

	typedef struct packed {
		logic [PCOUNT_W-1:0] pcount;
		logic [16:0]         h_step;
		logic [16:0]         noise_scale;
		logic [30:0]         coupling;
		logic [30:0]         spacing;
		logic                boundary_fixed;
		logic                damping_on;
	} cfg_t;

	// Per-particle controls for the update pipe
	typedef struct packed {
		logic act;
		logic end_l;
		logic end_r;
		logic use_l;
		logic use_r;
		logic damp;
	} upd_ctl_t;

	// Clamp a wide value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] val);
		logic signed [31:0] r;
		if (val > Q_MAX) begin
			r = 32'sh7fffffff;
		end else if (val < Q_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = val[31:0];
		end
		return r;
	endfunction

	// Fixed-point product: floor shift, then clamp
	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat32(p >>> FRAC_BITS);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lcs_cell.sv -----
// One chain cell: holds the displacement and velocity of one particle.
`default_nettype none

module lcs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  lcs_pkg::particle_t  d,
	output lcs_pkg::particle_t  q
);
	import lcs_pkg::*;

	particle_t part_q;

	// Take the neighbor's particle on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
		end else if (shift) begin
			part_q <= d;
		end
	end

	assign q = part_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lcs_force.sv -----
// Pipelined bond force unit: F(r) = 12 r^-13 - 6 r^-7 - 4 (r - a0)^3.
`default_nettype none

module lcs_force (
	input  logic               clk,
	input  logic               shift,
	input  logic signed [33:0] r_raw,
	input  logic [30:0]        spacing,
	output logic signed [31:0] force_out
);
	import lcs_pkg::*;

	typedef struct packed {
		logic [31:0]         rem;
		logic [DIV_BITS-1:0] quo;
		logic [31:0]         den;
		logic                neg;
		logic                tiny;
		logic signed [31:0]  gap;
	} div_t;

	logic signed [31:0] r_s1;
	div_t               div_in;
	div_t               div_s [1:DIV_STAGES];
	logic [31:0]        mag;
	logic signed [63:0] qv;
	logic signed [31:0] y_next;

	logic signed [31:0] y_s18, gap_s18;
	logic signed [31:0] y_s19, y2_s19, dd_s19, gap_s19;
	logic signed [31:0] y_s20, y3_s20, cube_s20;
	logic signed [31:0] y_s21, y6_s21, cube_s21;
	logic signed [31:0] y6_s22, y7_s22, cube_s22;
	logic signed [31:0] y7_s23, y13_s23, cube_s23;
	logic signed [31:0] force_s24;

	// Two restoring division steps on 2^(2F) / |r|
	function automatic div_t div_step(input div_t a);
		div_t        b;
		logic [32:0] t;
		int          k;
		b = a;
		for (k = 0; k < 2; k++) begin
			t = {b.rem, 1'b0};
			if (t >= {1'b0, b.den}) begin
				t = t - {1'b0, b.den};
				b.quo = {b.quo[DIV_BITS-2:0], 1'b1};
			end else begin
				b.quo = {b.quo[DIV_BITS-2:0], 1'b0};
			end
			b.rem = t[31:0];
		end
		return b;
	endfunction

	// Clamp the distance
	always_ff @(posedge clk) begin
		if (shift) begin
			r_s1 <= sat32(64'(r_raw));
		end
	end

	// Set up magnitude, sign and the cubic term's offset
	always_comb begin
		mag         = r_s1[31] ? (~r_s1 + 32'd1) : r_s1;
		div_in.rem  = 32'd1;
		div_in.quo  = '0;
		div_in.den  = mag;
		div_in.neg  = r_s1[31];
		div_in.tiny = (mag <= 32'd1);
		div_in.gap  = sat32(64'(r_s1) - signed'({33'b0, spacing}));
	end

	// Advance the divider stages
	always_ff @(posedge clk) begin
		if (shift) begin
			div_s[1] <= div_step(div_in);
			for (int g = 2; g <= DIV_STAGES; g++) begin
				div_s[g] <= div_step(div_s[g-1]);
			end
		end
	end

	// Sign and clamp the reciprocal; a zero or one-LSB distance saturates
	always_comb begin
		qv = signed'(64'({1'b0, div_s[DIV_STAGES].quo}));
		if (div_s[DIV_STAGES].tiny) begin
			y_next = div_s[DIV_STAGES].neg ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			y_next = sat32(div_s[DIV_STAGES].neg ? -qv : qv);
		end
	end

	// Power chain and cube over the multiply stages, then the weighted sum
	always_ff @(posedge clk) begin
		if (shift) begin
			y_s18    <= y_next;
			gap_s18  <= div_s[DIV_STAGES].gap;

			y_s19    <= y_s18;
			y2_s19   <= mulq(y_s18, y_s18);
			dd_s19   <= mulq(gap_s18, gap_s18);
			gap_s19  <= gap_s18;

			y_s20    <= y_s19;
			y3_s20   <= mulq(y2_s19, y_s19);
			cube_s20 <= mulq(dd_s19, gap_s19);

			y_s21    <= y_s20;
			y6_s21   <= mulq(y3_s20, y3_s20);
			cube_s21 <= cube_s20;

			y6_s22   <= y6_s21;
			y7_s22   <= mulq(y6_s21, y_s21);
			cube_s22 <= cube_s21;

			y7_s23   <= y7_s22;
			y13_s23  <= mulq(y7_s22, y6_s22);
			cube_s23 <= cube_s22;

			force_s24 <= sat32(64'(y13_s23) * 64'sd12 - 64'(y7_s23) * 64'sd6
				- 64'(cube_s23) * 64'sd4);
		end
	end

	assign force_out = force_s24;

endmodule

`default_nettype wire

// ----- hw/rtl/lcs_update.sv -----
// Update pipe: integrates one particle per cycle while shift is high, from its two bond forces.
`default_nettype none

module lcs_update (
	input  logic                clk,
	input  logic                shift,
	input  lcs_pkg::particle_t  p_in,
	input  lcs_pkg::upd_ctl_t   ctl,
	input  logic signed [31:0]  f_cur,
	input  logic signed [31:0]  f_next,
	input  logic [16:0]         h_step,
	input  logic [16:0]         noise_scale,
	input  logic [30:0]         coupling,
	input  logic signed [31:0]  l_noise,
	input  logic signed [31:0]  r_noise,
	output lcs_pkg::particle_t  p_out
);
	import lcs_pkg::*;

	logic signed [31:0] h32, ns32, cp32, noise_sel;

	logic signed [31:0] x_s1, v_s1, hv_s1, damp_s1, nz_s1, fl_s1, fr_s1;
	logic               act_s1;
	logic signed [31:0] x_s2, v_s2, hv_s2, nz_s2, acc_s2;
	logic               act_s2;
	logic signed [31:0] x_s3, v_s3, hv_s3, nz_s3, ha_s3;
	logic               act_s3;
	particle_t          out_s4;

	assign h32       = signed'({15'b0, h_step});
	assign ns32      = signed'({15'b0, noise_scale});
	assign cp32      = signed'({1'b0, coupling});
	assign noise_sel = ctl.end_l ? l_noise : r_noise;

	always_ff @(posedge clk) begin
		if (shift) begin
			// Products of old velocity, damping, bath noise; pick the bond forces
			x_s1    <= p_in.x;
			v_s1    <= p_in.v;
			act_s1  <= ctl.act;
			hv_s1   <= mulq(h32, p_in.v);
			damp_s1 <= ctl.damp ? mulq(cp32, p_in.v) : 32'sd0;
			nz_s1   <= (ctl.end_l || ctl.end_r) ? mulq(ns32, noise_sel) : 32'sd0;
			fl_s1   <= ctl.use_l ? f_cur : 32'sd0;
			fr_s1   <= ctl.use_r ? f_next : 32'sd0;

			// Sum the acceleration
			x_s2   <= x_s1;
			v_s2   <= v_s1;
			act_s2 <= act_s1;
			hv_s2  <= hv_s1;
			nz_s2  <= nz_s1;
			acc_s2 <= sat32(64'(fl_s1) - 64'(fr_s1) - 64'(damp_s1));

			// Scale by the time step
			x_s3   <= x_s2;
			v_s3   <= v_s2;
			act_s3 <= act_s2;
			hv_s3  <= hv_s2;
			nz_s3  <= nz_s2;
			ha_s3  <= mulq(h32, acc_s2);

			// Write the new state, or pass the particle through untouched
			if (act_s3) begin
				out_s4.x <= sat32(64'(x_s3) + 64'(hv_s3));
				out_s4.v <= sat32(64'(v_s3) + 64'(ha_s3) + 64'(nz_s3));
			end else begin
				out_s4.x <= x_s3;
				out_s4.v <= v_s3;
			end
		end
	end

	assign p_out = out_s4;

endmodule

`default_nettype wire

// ----- hw/rtl/langevin_chain_step_unit.sv -----
// Top level of the Langevin chain step unit: cell ring, force pipe and update pipe.
//
//   channel | signals                          | direction
//   request | req_valid, req_stall, req        | in  (stall driven here)
//   result  | res_valid, res_stall, res        | out (stall driven by sink)
//   config  | cfg_write, cfg_index, cfg_data   | in  (write only)
//
// Step, write and read requests each take one full turn of the particle ring after the
// accepting edge; req_stall stays high for the whole turn, and a read held by res_stall
// stretches it, so a new request is taken only once the last one has finished.
// The turn length is set by the cell ring, the force pipe, whose 16-stage reciprocal
// divider dominates it, and the update pipe. Mode 3 is accepted and does nothing.
// Reset clears all particles to zero and loads the register defaults.
// A read result waiting under res_stall freezes the ring at the next capture.
`default_nettype none

module langevin_chain_step_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  lcs_pkg::req_t                     req,
	output logic                              res_valid,
	input  logic                              res_stall,
	output lcs_pkg::res_t                     res,
	input  logic                              cfg_write,
	input  logic [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lcs_pkg::*;

	cfg_t               cfg_q;
	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         op_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [31:0] wpos_q, wvel_q, lnoise_q, rnoise_q;
	logic               res_valid_q;
	res_t               res_q;

	particle_t          cell_out [0:MAX_PARTICLES-1];
	particle_t          cell_in  [0:MAX_PARTICLES-1];
	particle_t          dly_q    [0:FORCE_LAT];
	particle_t          upd_out;
	particle_t          head;
	logic signed [31:0] prev_q, fprev_q, force_now;
	logic signed [33:0] r_raw, a0_ext;
	logic [NW-1:0]      n_eff;
	logic               at_idx, capture, hold, shift_en, last;
	logic [CNT_W-1:0]   i_raw;
	logic [IDX_W-1:0]   i_part;
	logic               in_range;
	upd_ctl_t           ctl;

	assign head   = cell_out[0];
	assign a0_ext = signed'({3'b0, cfg_q.spacing});

	// Clamp the chain length to between 2 and the store size
	always_comb begin
		if (cfg_q.pcount < PCOUNT_W'(2)) begin
			n_eff = NW'(2);
		end else if (cfg_q.pcount > PCOUNT_W'(MAX_PARTICLES)) begin
			n_eff = NW'(MAX_PARTICLES);
		end else begin
			n_eff = NW'(cfg_q.pcount);
		end
	end

	// Ring sequencing and read hold
	assign at_idx    = (cnt_q == CNT_W'(idx_q));
	assign hold      = busy_q && (op_q == MODE_READ) && at_idx && res_valid_q && res_stall;
	assign shift_en  = busy_q && !hold;
	assign capture   = shift_en && (op_q == MODE_READ) && at_idx;
	assign last      = (cnt_q == CNT_W'(RING_LEN - 1));
	assign req_stall = busy_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Bond distance fed to the force pipe: left wall, inner bond, right wall
	always_comb begin
		if (cnt_q == '0) begin
			r_raw = 34'(head.x) + a0_ext;
		end else if (cnt_q < CNT_W'(n_eff)) begin
			r_raw = 34'(head.x) - 34'(prev_q) + a0_ext;
		end else begin
			r_raw = a0_ext - 34'(prev_q);
		end
	end

	// Controls for the particle entering the update pipe
	always_comb begin
		i_raw     = cnt_q - CNT_W'(FORCE_LAT + 1);
		i_part    = i_raw[IDX_W-1:0];
		in_range  = (cnt_q >= CNT_W'(FORCE_LAT + 1))
			&& (cnt_q < CNT_W'(FORCE_LAT + 1 + MAX_PARTICLES));
		ctl.end_l = (i_part == '0);
		ctl.end_r = ({1'b0, i_part} == n_eff - NW'(1));
		ctl.act   = (op_q == MODE_STEP) && in_range && ({1'b0, i_part} < n_eff);
		ctl.use_l = !(ctl.end_l && !cfg_q.boundary_fixed);
		ctl.use_r = !(ctl.end_r && !cfg_q.boundary_fixed);
		ctl.damp  = cfg_q.damping_on && (ctl.end_l || ctl.end_r);
	end

	// Chain cells, each handing its particle toward the head
	always_comb begin
		for (int k = 0; k < MAX_PARTICLES - 1; k++) begin
			cell_in[k] = cell_out[k+1];
		end
		cell_in[MAX_PARTICLES-1] = upd_out;
	end

	for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
		lcs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift_en),
			.d      (cell_in[k]),
			.q      (cell_out[k])
		);
	end

	lcs_force u_force (
		.clk       (clk),
		.shift     (shift_en),
		.r_raw     (r_raw),
		.spacing   (cfg_q.spacing),
		.force_out (force_now)
	);

	lcs_update u_update (
		.clk         (clk),
		.shift       (shift_en),
		.p_in        (dly_q[FORCE_LAT]),
		.ctl         (ctl),
		.f_cur       (fprev_q),
		.f_next      (force_now),
		.h_step      (cfg_q.h_step),
		.noise_scale (cfg_q.noise_scale),
		.coupling    (cfg_q.coupling),
		.l_noise     (lnoise_q),
		.r_noise     (rnoise_q),
		.p_out       (upd_out)
	);

	// Delay line alongside the force pipe; insert written particle at the head
	always_ff @(posedge clk) begin
		if (shift_en) begin
			if ((op_q == MODE_WRITE) && at_idx) begin
				dly_q[0].x <= wpos_q;
				dly_q[0].v <= wvel_q;
			end else begin
				dly_q[0] <= head;
			end
			for (int j = 1; j <= FORCE_LAT; j++) begin
				dly_q[j] <= dly_q[j-1];
			end
			prev_q  <= head.x;
			fprev_q <= force_now;
		end
	end

	// Latch request payload and read data
	always_ff @(posedge clk) begin
		if (req_valid && !busy_q) begin
			idx_q    <= req.particle_index[IDX_W-1:0];
			wpos_q   <= req.write_position;
			wvel_q   <= req.write_velocity;
			lnoise_q <= req.left_noise;
			rnoise_q <= req.right_noise;
		end
		if (capture) begin
			res_q.read_position <= head.x;
			res_q.read_velocity <= head.v;
		end
	end

	// Request control and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			op_q        <= MODE_STEP;
			res_valid_q <= 1'b0;
		end else begin
			if (capture) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (req_valid && !busy_q) begin
				if (req.mode != MODE_NONE) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					op_q   <= req.mode;
				end
			end else if (shift_en) begin
				if (last) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pcount         <= PCOUNT_W'(64);
			cfg_q.h_step         <= 17'd66;
			cfg_q.noise_scale    <= 17'd2072;
			cfg_q.coupling       <= 31'd65536;
			cfg_q.spacing        <= 31'd65536;
			cfg_q.boundary_fixed <= 1'b1;
			cfg_q.damping_on     <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PCOUNT:   cfg_q.pcount         <= cfg_data[PCOUNT_W-1:0];
				CFG_STEP:     cfg_q.h_step         <= cfg_data[16:0];
				CFG_NOISE:    cfg_q.noise_scale    <= cfg_data[16:0];
				CFG_COUPLING: cfg_q.coupling       <= cfg_data[30:0];
				CFG_SPACING:  cfg_q.spacing        <= cfg_data[30:0];
				CFG_BOUNDARY: cfg_q.boundary_fixed <= cfg_data[0];
				CFG_DAMPING:  cfg_q.damping_on     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire
